// ===== rtl/mpfm_pkg.sv =====
// ----------------------------------------------------------------------------
// mpfm_pkg: shared types, constants and helpers for the mip fallback map
// Field widths, command and state codes, and elaboration-time helpers that
// size the packed pyramid store.
// ----------------------------------------------------------------------------
package mpfm_pkg;

  localparam int unsigned TILE_SIZE_DEF      = 32;
  localparam int unsigned MAX_MIP_LEVELS_DEF = 6;
  localparam int unsigned ENTRY_BITS_DEF     = 32;

  localparam int unsigned KIND_W     = 2;
  localparam int unsigned COORD_IN_W = 5;
  localparam int unsigned MIP_W      = 3;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned CFG_W      = 3;
  localparam int unsigned COUNT_W    = 11;

  localparam logic [CFG_W-1:0]   LEVELS_RESET = 3'd6;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_SET     = 2'd0,
    KIND_CLEAR   = 2'd1,
    KIND_PROCESS = 2'd2,
    KIND_READ    = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_CLR,    // zero sweep over the raw store
    ST_IDLE,
    ST_ADDR,   // range check, address calc
    ST_MEM,    // store read issued
    ST_USE,    // read data back
    ST_PLVL,   // fallback pass: level start
    ST_PBASE,  // fallback pass: level base address back
    ST_PADDR,  // fallback pass: parent address calc
    ST_PRD,    // fallback pass: raw + parent read
    ST_PWR,    // fallback pass: processed write
    ST_FIN     // result into output register
  } state_e;

  function automatic int unsigned level_side(int unsigned tile, int unsigned m);
    if (m >= 31) begin
      return 0;
    end
    return tile >> m;
  endfunction

  function automatic int unsigned level_offset(int unsigned tile, int unsigned m);
    int unsigned off;
    off = 0;
    for (int unsigned k = 0; k < m; k++) begin
      off += level_side(tile, k) * level_side(tile, k);
    end
    return off;
  endfunction

  function automatic int unsigned store_depth(int unsigned tile, int unsigned levels);
    return level_offset(tile, levels);
  endfunction

  function automatic int unsigned addr_w(int unsigned tile, int unsigned levels);
    return $clog2(store_depth(tile, levels));
  endfunction

  function automatic int unsigned coord_w(int unsigned tile);
    return $clog2(tile);
  endfunction

  function automatic int unsigned side_w(int unsigned tile);
    return $clog2(tile + 1);
  endfunction

  function automatic int unsigned lvl_w(int unsigned levels);
    return (levels > 1) ? $clog2(levels) : 1;
  endfunction

endpackage

// ===== rtl/mpfm_if.sv =====
// ----------------------------------------------------------------------------
// mpfm_if: valid/ready channels of the mip fallback map
// Command word in, result word out, and the level-count config write.
// ----------------------------------------------------------------------------
interface mpfm_in_if;
  logic                              valid;
  logic                              ready;
  logic [mpfm_pkg::KIND_W-1:0]       kind;
  logic [mpfm_pkg::COORD_IN_W-1:0]   x;
  logic [mpfm_pkg::COORD_IN_W-1:0]   y;
  logic [mpfm_pkg::MIP_W-1:0]        mip;
  logic [mpfm_pkg::DATA_W-1:0]       entry_data;
  logic                              entry_valid;

  modport source (output valid, kind, x, y, mip, entry_data, entry_valid, input ready);
  modport sink   (input valid, kind, x, y, mip, entry_data, entry_valid, output ready);
endinterface

interface mpfm_out_if;
  logic                              valid;
  logic                              ready;
  logic [mpfm_pkg::DATA_W-1:0]       read_data;
  logic                              read_valid;
  logic                              in_range;
  logic [mpfm_pkg::COUNT_W-1:0]      valid_count;

  modport source (output valid, read_data, read_valid, in_range, valid_count, input ready);
  modport sink   (input valid, read_data, read_valid, in_range, valid_count, output ready);
endinterface

interface mpfm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [mpfm_pkg::CFG_W-1:0]        data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/mip_pyramid_fallback_map.sv =====
// ----------------------------------------------------------------------------
// mip_pyramid_fallback_map: indirection mip pyramid with coarse-to-fine fill
// Raw and processed pyramid stores, a shared address unit and a sequencer.
// ----------------------------------------------------------------------------
// One command word is taken at a time; in_i.ready is high only while idle,
// and each command returns exactly one result word through a one-deep output
// register, so the next command can be taken while a result waits. Set and
// read step through address, store read, update and finish; out-of-range
// coordinates or levels go from address straight to finish. A clear runs a
// zero sweep over all DEPTH entries of the raw store (1365 at the default
// 32x32, 6-level pyramid) and then finishes; a fallback pass walks the used
// levels coarse to fine, with a level start and base lookup per level and a
// parent address, read and write per entry, then finishes. The block is ready
// again the cycle after the result load; the finish cycle stretches while an
// earlier result word still waits. After reset the same zero sweep zeroes the
// raw store before the first command is taken; config writes are taken at
// any time but belong only where no command is in flight. Reading a
// processed entry before any fallback pass wrote it returns whatever the
// store holds.
// ----------------------------------------------------------------------------
module mip_pyramid_fallback_map #(
  parameter int unsigned TILE_SIZE      = mpfm_pkg::TILE_SIZE_DEF,
  parameter int unsigned MAX_MIP_LEVELS = mpfm_pkg::MAX_MIP_LEVELS_DEF,
  parameter int unsigned ENTRY_BITS     = mpfm_pkg::ENTRY_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  mpfm_cfg_if.sink      cfg_i,
  mpfm_in_if.sink       in_i,
  mpfm_out_if.source    out_o
);

  localparam int unsigned DEPTH = mpfm_pkg::store_depth(TILE_SIZE, MAX_MIP_LEVELS);
  localparam int unsigned AW    = mpfm_pkg::addr_w(TILE_SIZE, MAX_MIP_LEVELS);
  localparam int unsigned CW    = mpfm_pkg::coord_w(TILE_SIZE);
  localparam int unsigned SW    = mpfm_pkg::side_w(TILE_SIZE);
  localparam int unsigned LW    = mpfm_pkg::lvl_w(MAX_MIP_LEVELS);
  localparam int unsigned NW    = $clog2(MAX_MIP_LEVELS + 1);
  localparam int unsigned MW    = ((NW > mpfm_pkg::MIP_W) ? NW : mpfm_pkg::MIP_W) + 1;
  localparam int unsigned IW    = (SW > mpfm_pkg::COORD_IN_W) ? SW : mpfm_pkg::COORD_IN_W;
  localparam int unsigned EW    = ENTRY_BITS + 1;  // payload + valid flag on top

  // --------------------------------------------------------------------------
  // Level side table (elaboration constants)
  // --------------------------------------------------------------------------
  logic [SW-1:0] side_tab [MAX_MIP_LEVELS];

  for (genvar g = 0; g < MAX_MIP_LEVELS; g++) begin : g_side
    assign side_tab[g] = SW'(mpfm_pkg::level_side(TILE_SIZE, g));
  end

  // --------------------------------------------------------------------------
  // State and registers
  // --------------------------------------------------------------------------
  mpfm_pkg::state_e state_q, state_d;

  logic [mpfm_pkg::CFG_W-1:0]      levels_q;
  logic [mpfm_pkg::COUNT_W-1:0]    count_q;
  logic [AW-1:0]                   clr_q;
  logic                            clr_item_q;
  logic [LW-1:0]                   lvl_q;
  logic [CW-1:0]                   px_q, py_q;
  logic                            out_valid_q;

  // command word, captured at accept
  mpfm_pkg::kind_e                 kind_q;
  logic [mpfm_pkg::COORD_IN_W-1:0] x_q, y_q;
  logic [mpfm_pkg::MIP_W-1:0]      mip_q;
  logic [ENTRY_BITS-1:0]           data_q;
  logic                            nv_q;

  logic [AW-1:0]                   d_q;
  logic                            ok_q;
  logic [mpfm_pkg::DATA_W-1:0]     res_data_q;
  logic                            res_rv_q;

  logic [mpfm_pkg::DATA_W-1:0]     out_data_q;
  logic                            out_rv_q;
  logic                            out_ok_q;
  logic [mpfm_pkg::COUNT_W-1:0]    out_count_q;

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  logic in_acc;
  logic out_free;
  logic clr_last;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == mpfm_pkg::ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;
  assign clr_last    = (clr_q == AW'(DEPTH - 1));

  // --------------------------------------------------------------------------
  // Effective level count: 0 reads as 1, anything above the max as the max
  // --------------------------------------------------------------------------
  logic [NW-1:0] lvls;
  logic [LW-1:0] top_lvl;

  always_comb begin
    if (levels_q == '0) begin
      lvls = NW'(1);
    end else if (MW'(levels_q) > MW'(MAX_MIP_LEVELS)) begin
      lvls = NW'(MAX_MIP_LEVELS);
    end else begin
      lvls = NW'(levels_q);
    end
  end

  assign top_lvl = LW'(lvls - NW'(1));

  // --------------------------------------------------------------------------
  // Range check for set / read
  // --------------------------------------------------------------------------
  logic          mip_ok;
  logic [LW-1:0] mip_lvl;
  logic [SW-1:0] side_m;
  logic          coord_ok;

  assign mip_ok   = MW'(mip_q) < MW'(lvls);
  assign mip_lvl  = mip_ok ? LW'(mip_q) : '0;
  assign side_m   = side_tab[mip_lvl];
  assign coord_ok = mip_ok && (IW'(x_q) < IW'(side_m)) && (IW'(y_q) < IW'(side_m));

  // --------------------------------------------------------------------------
  // Fallback walk: current fine entry and its clamped parent
  // --------------------------------------------------------------------------
  logic [SW-1:0] fs, cs;
  logic          is_top;
  logic [LW-1:0] pidx;
  logic          use_parent;
  logic [CW-1:0] cx_half, cy_half, cx, cy;
  logic          last_px, last_py;

  assign fs         = side_tab[lvl_q];
  assign is_top     = (lvl_q == top_lvl);
  assign pidx       = is_top ? lvl_q : LW'(lvl_q + LW'(1));
  assign cs         = side_tab[pidx];
  // coarsest used level and levels over an empty parent copy raw as is
  assign use_parent = !is_top && (cs != '0);
  assign cx_half    = px_q >> 1;
  assign cy_half    = py_q >> 1;
  // odd sides: clamp parent to last row / column of the coarser level
  assign cx         = (SW'(cx_half) >= cs) ? CW'(cs - SW'(1)) : cx_half;
  assign cy         = (SW'(cy_half) >= cs) ? CW'(cs - SW'(1)) : cy_half;
  assign last_px    = (px_q == CW'(fs - SW'(1)));
  assign last_py    = (py_q == CW'(fs - SW'(1)));

  // --------------------------------------------------------------------------
  // Shared address unit
  // --------------------------------------------------------------------------
  logic [LW-1:0] u_lvl;
  logic [CW-1:0] u_row, u_col;
  logic [AW-1:0] u_addr;

  mpfm_addr_unit #(
    .TILE_SIZE      (TILE_SIZE),
    .MAX_MIP_LEVELS (MAX_MIP_LEVELS)
  ) u_addr_unit (
    .clk_i  (clk_i),
    .lvl_i  (u_lvl),
    .row_i  (u_row),
    .col_i  (u_col),
    .addr_o (u_addr)
  );

  // --------------------------------------------------------------------------
  // Stores: raw (set / clear) and processed (fallback output)
  // --------------------------------------------------------------------------
  logic          raw_we, raw_re, proc_we, proc_re;
  logic [AW-1:0] raw_waddr, raw_raddr, proc_waddr, proc_raddr;
  logic [EW-1:0] raw_wdata, raw_rdata, proc_wdata, proc_rdata;

  mpfm_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_raw_ram (
    .clk_i   (clk_i),
    .we_i    (raw_we),
    .waddr_i (raw_waddr),
    .wdata_i (raw_wdata),
    .re_i    (raw_re),
    .raddr_i (raw_raddr),
    .rdata_o (raw_rdata)
  );

  mpfm_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_proc_ram (
    .clk_i   (clk_i),
    .we_i    (proc_we),
    .waddr_i (proc_waddr),
    .wdata_i (proc_wdata),
    .re_i    (proc_re),
    .raddr_i (proc_raddr),
    .rdata_o (proc_rdata)
  );

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mpfm_pkg::ST_CLR: begin
        if (clr_last) begin
          state_d = clr_item_q ? mpfm_pkg::ST_FIN : mpfm_pkg::ST_IDLE;
        end
      end
      mpfm_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (mpfm_pkg::kind_e'(in_i.kind))
            mpfm_pkg::KIND_SET,
            mpfm_pkg::KIND_READ:    state_d = mpfm_pkg::ST_ADDR;
            mpfm_pkg::KIND_CLEAR:   state_d = mpfm_pkg::ST_CLR;
            mpfm_pkg::KIND_PROCESS: state_d = mpfm_pkg::ST_PLVL;
            default:                state_d = mpfm_pkg::ST_IDLE;
          endcase
        end
      end
      mpfm_pkg::ST_ADDR:  state_d = coord_ok ? mpfm_pkg::ST_MEM : mpfm_pkg::ST_FIN;
      mpfm_pkg::ST_MEM:   state_d = mpfm_pkg::ST_USE;
      mpfm_pkg::ST_USE:   state_d = mpfm_pkg::ST_FIN;
      mpfm_pkg::ST_PLVL: begin
        if (fs != '0) begin
          state_d = mpfm_pkg::ST_PBASE;
        end else if (lvl_q == '0) begin
          state_d = mpfm_pkg::ST_FIN;
        end
      end
      mpfm_pkg::ST_PBASE: state_d = mpfm_pkg::ST_PADDR;
      mpfm_pkg::ST_PADDR: state_d = mpfm_pkg::ST_PRD;
      mpfm_pkg::ST_PRD:   state_d = mpfm_pkg::ST_PWR;
      mpfm_pkg::ST_PWR: begin
        if (!(last_px && last_py)) begin
          state_d = mpfm_pkg::ST_PADDR;
        end else if (lvl_q == '0) begin
          state_d = mpfm_pkg::ST_FIN;
        end else begin
          state_d = mpfm_pkg::ST_PLVL;
        end
      end
      mpfm_pkg::ST_FIN: begin
        if (out_free) begin
          state_d = mpfm_pkg::ST_IDLE;
        end
      end
      default: state_d = mpfm_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Store and address unit controls
  // --------------------------------------------------------------------------
  always_comb begin
    raw_we     = 1'b0;
    raw_waddr  = clr_q;
    raw_wdata  = '0;
    raw_re     = 1'b0;
    raw_raddr  = u_addr;
    proc_we    = 1'b0;
    proc_waddr = d_q;
    proc_wdata = raw_rdata;
    proc_re    = 1'b0;
    proc_raddr = u_addr;
    // parent lookup unless a state needs the unit for something else
    u_lvl      = pidx;
    u_row      = cy;
    u_col      = cx;
    unique case (state_q)
      mpfm_pkg::ST_CLR: begin
        raw_we = 1'b1;
      end
      mpfm_pkg::ST_ADDR: begin
        u_lvl = mip_lvl;
        u_row = CW'(y_q);
        u_col = CW'(x_q);
      end
      mpfm_pkg::ST_MEM: begin
        // keep the unit on the entry so its address is still there in ST_USE
        u_lvl   = mip_lvl;
        u_row   = CW'(y_q);
        u_col   = CW'(x_q);
        raw_re  = (kind_q == mpfm_pkg::KIND_SET);
        proc_re = (kind_q == mpfm_pkg::KIND_READ);
      end
      mpfm_pkg::ST_USE: begin
        // hold the address unit on the same entry for the write-back
        u_lvl     = mip_lvl;
        u_row     = CW'(y_q);
        u_col     = CW'(x_q);
        raw_we    = (kind_q == mpfm_pkg::KIND_SET);
        raw_waddr = u_addr;
        raw_wdata = {nv_q, data_q};
      end
      mpfm_pkg::ST_PLVL: begin
        u_lvl = lvl_q;
        u_row = '0;
        u_col = '0;
      end
      mpfm_pkg::ST_PRD: begin
        raw_re    = 1'b1;
        raw_raddr = d_q;
        proc_re   = use_parent;
      end
      mpfm_pkg::ST_PWR: begin
        proc_we    = 1'b1;
        proc_wdata = (!use_parent || raw_rdata[ENTRY_BITS]) ? raw_rdata : proc_rdata;
      end
      mpfm_pkg::ST_IDLE,
      mpfm_pkg::ST_PBASE,
      mpfm_pkg::ST_PADDR,
      mpfm_pkg::ST_FIN: begin
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mpfm_pkg::ST_CLR;
      levels_q    <= mpfm_pkg::LEVELS_RESET;
      count_q     <= '0;
      clr_q       <= '0;
      clr_item_q  <= 1'b0;
      lvl_q       <= '0;
      px_q        <= '0;
      py_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_i.valid) begin
        levels_q <= cfg_i.data;
      end

      if (in_acc) begin
        clr_item_q <= 1'b1;
        clr_q      <= '0;
        lvl_q      <= top_lvl;
        if (mpfm_pkg::kind_e'(in_i.kind) == mpfm_pkg::KIND_CLEAR) begin
          count_q <= '0;
        end
      end

      if (state_q == mpfm_pkg::ST_CLR) begin
        clr_q <= AW'(clr_q + AW'(1));
      end

      // running count of valid raw entries, saturating both ways
      if (state_q == mpfm_pkg::ST_USE && kind_q == mpfm_pkg::KIND_SET) begin
        if (raw_rdata[ENTRY_BITS] && !nv_q && count_q != '0) begin
          count_q <= count_q - mpfm_pkg::COUNT_W'(1);
        end else if (!raw_rdata[ENTRY_BITS] && nv_q && count_q != mpfm_pkg::COUNT_MAX) begin
          count_q <= count_q + mpfm_pkg::COUNT_W'(1);
        end
      end

      if (state_q == mpfm_pkg::ST_PLVL) begin
        px_q <= '0;
        py_q <= '0;
        if (fs == '0 && lvl_q != '0) begin
          lvl_q <= LW'(lvl_q - LW'(1));
        end
      end

      if (state_q == mpfm_pkg::ST_PWR) begin
        if (!last_px) begin
          px_q <= CW'(px_q + CW'(1));
        end else begin
          px_q <= '0;
          py_q <= CW'(py_q + CW'(1));
          if (last_py && lvl_q != '0) begin
            lvl_q <= LW'(lvl_q - LW'(1));
          end
        end
      end

      if (state_q == mpfm_pkg::ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q     <= mpfm_pkg::kind_e'(in_i.kind);
      x_q        <= in_i.x;
      y_q        <= in_i.y;
      mip_q      <= in_i.mip;
      data_q     <= ENTRY_BITS'(in_i.entry_data);
      nv_q       <= in_i.entry_valid;
      ok_q       <= 1'b0;
      res_data_q <= '0;
      res_rv_q   <= 1'b0;
    end

    if (state_q == mpfm_pkg::ST_ADDR) begin
      ok_q <= coord_ok;
    end

    if (state_q == mpfm_pkg::ST_USE && kind_q == mpfm_pkg::KIND_READ) begin
      res_data_q <= mpfm_pkg::DATA_W'(proc_rdata[ENTRY_BITS-1:0]);
      res_rv_q   <= proc_rdata[ENTRY_BITS];
    end

    if (state_q == mpfm_pkg::ST_PBASE) begin
      d_q <= u_addr;
    end else if (state_q == mpfm_pkg::ST_PWR) begin
      d_q <= AW'(d_q + AW'(1));
    end

    if (state_q == mpfm_pkg::ST_FIN && out_free) begin
      out_data_q  <= res_data_q;
      out_rv_q    <= res_rv_q;
      out_ok_q    <= ok_q;
      out_count_q <= count_q;
    end
  end

  // --------------------------------------------------------------------------
  // Result word
  // --------------------------------------------------------------------------
  assign out_o.valid       = out_valid_q;
  assign out_o.read_data   = out_data_q;
  assign out_o.read_valid  = out_rv_q;
  assign out_o.in_range    = out_ok_q;
  assign out_o.valid_count = out_count_q;

endmodule

// ===== rtl/mpfm_ram.sv =====
// ----------------------------------------------------------------------------
// mpfm_ram: single-port-write, single-port-read store
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mpfm_ram #(
  parameter  int unsigned WIDTH = mpfm_pkg::ENTRY_BITS_DEF + 1,
  parameter  int unsigned DEPTH = mpfm_pkg::store_depth(mpfm_pkg::TILE_SIZE_DEF,
                                                         mpfm_pkg::MAX_MIP_LEVELS_DEF),
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mpfm_addr_unit.sv =====
// ----------------------------------------------------------------------------
// mpfm_addr_unit: shared pyramid address calculator
// addr = level_offset(lvl) + row * side(lvl) + col, registered.
// ----------------------------------------------------------------------------
module mpfm_addr_unit #(
  parameter  int unsigned TILE_SIZE      = mpfm_pkg::TILE_SIZE_DEF,
  parameter  int unsigned MAX_MIP_LEVELS = mpfm_pkg::MAX_MIP_LEVELS_DEF,
  localparam int unsigned AW = mpfm_pkg::addr_w(TILE_SIZE, MAX_MIP_LEVELS),
  localparam int unsigned CW = mpfm_pkg::coord_w(TILE_SIZE),
  localparam int unsigned SW = mpfm_pkg::side_w(TILE_SIZE),
  localparam int unsigned LW = mpfm_pkg::lvl_w(MAX_MIP_LEVELS)
) (
  input  logic          clk_i,
  input  logic [LW-1:0] lvl_i,
  input  logic [CW-1:0] row_i,
  input  logic [CW-1:0] col_i,
  output logic [AW-1:0] addr_o
);

  logic [SW-1:0]    side_tab [MAX_MIP_LEVELS];
  logic [AW-1:0]    off_tab  [MAX_MIP_LEVELS];
  logic [CW+SW-1:0] prod;
  logic [AW-1:0]    addr_q;

  for (genvar g = 0; g < MAX_MIP_LEVELS; g++) begin : g_tab
    assign side_tab[g] = SW'(mpfm_pkg::level_side(TILE_SIZE, g));
    assign off_tab[g]  = AW'(mpfm_pkg::level_offset(TILE_SIZE, g));
  end

  assign prod = (CW+SW)'(row_i) * (CW+SW)'(side_tab[lvl_i]);

  always_ff @(posedge clk_i) begin
    addr_q <= AW'(off_tab[lvl_i] + AW'(prod) + AW'(col_i));
  end

  assign addr_o = addr_q;

endmodule
